// ===== src/char_lcd_expander_byte_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the character display byte encoder
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_EXPANDER_BYTE_ENCODER_TOP_ASSERT_SVH
`define CHAR_LCD_EXPANDER_BYTE_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication
`define CLBE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("clbe assertion failed");

// Next-cycle implication
`define CLBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("clbe assertion failed");

`endif

// ===== src/clbe_pkg.sv =====
// ----------------------------------------------------------------------------
// clbe_pkg
// Types and constants shared by the character display byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package clbe_pkg;

    // Request codes
    localparam logic [1:0] ACT_CMD    = 2'd0;
    localparam logic [1:0] ACT_CHAR   = 2'd1;
    localparam logic [1:0] ACT_CURSOR = 2'd2;
    localparam logic [1:0] ACT_NUMBER = 2'd3;

    // Decimal conversion sizes
    localparam int MAG_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int ITER_W     = $clog2(MAG_W);
    localparam int LEFT_W     = $clog2(BCD_DIGITS + 1);

    // Display byte constants
    localparam logic [7:0] CURSOR_CMD   = 8'h80;
    localparam logic [7:0] MINUS_CHAR   = 8'h2D;
    localparam logic [3:0] DIGIT_HI     = 4'h3;
    localparam logic [1:0] MAX_ROW      = 2'd3;

    // Expander low nibble: backlight bit 3, enable bit 2, register select bit 0
    localparam logic [3:0] CTL_ON_CMD   = 4'hC;
    localparam logic [3:0] CTL_OFF_CMD  = 4'h8;
    localparam logic [3:0] CTL_ON_CHAR  = 4'hD;
    localparam logic [3:0] CTL_OFF_CHAR = 4'h9;

    // Row start addresses of the display memory
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            default: base = 8'h54;
        endcase
        return base;
    endfunction

    // Display byte handed to the serializer
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       is_char;
        logic       last_byte;
    } t_ser_req;

    // Control of the decimal converter
    typedef struct packed {
        logic start;
        logic shift;
    } t_bcd_ctrl;

    // Status of the decimal converter
    typedef struct packed {
        logic       done;
        logic [3:0] top_digit;
    } t_bcd_stat;

endpackage

`default_nettype wire

// ===== src/char_lcd_expander_byte_encoder_top.sv =====
// Command, character and cursor requests pass through the S_SINGLE state to
//   the serializer; four beats follow. A new request is taken only in S_IDLE.
// Integer requests: the shared shift-and-add-3 unit converts the magnitude,
//   then up to 9 leading zero digits are trimmed (at least one is kept), then
//   four beats per character follow (max 44 beats with the sign).
// Reset (synchronous, active low) idles the sequencer and drops pending beats.
// ----------------------------------------------------------------------------
// char_lcd_expander_byte_encoder_top
// Turns display requests into expander bytes for a 4-bit display controller.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_expander_byte_encoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [7:0]  i_column,
    input  wire logic [7:0]  i_row,
    input  wire logic signed [31:0] i_number,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_expander_byte,
    output logic             o_last
);
    import clbe_pkg::*;

`include "char_lcd_expander_byte_encoder_top_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_CONV,
        S_TRIM,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state            r_state, n_state;
    logic [7:0]        r_byte, n_byte;
    logic              r_is_char, n_is_char;
    logic              r_neg, n_neg;
    logic [LEFT_W-1:0] r_left, n_left;

    t_ser_req   ser_req;
    logic       ser_ready;
    t_bcd_ctrl  bcd_ctrl;
    t_bcd_stat  bcd_stat;
    logic       in_beat;
    logic [1:0] row_clamp;
    logic [7:0] cursor_addr;
    logic [31:0] mag;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;

    // Clamp the row and form the cursor address
    assign row_clamp   = (i_row > 8'(MAX_ROW)) ? MAX_ROW : i_row[1:0];
    assign cursor_addr = i_column + row_base(row_clamp);
    assign mag         = i_number[31] ? (32'd0 - i_number) : i_number;

    // Sequence the request
    always_comb begin
        n_state   = r_state;
        n_byte    = r_byte;
        n_is_char = r_is_char;
        n_neg     = r_neg;
        n_left    = r_left;
        ser_req   = '0;
        bcd_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    case (i_action)
                        ACT_CMD: begin
                            n_byte    = i_byte_value;
                            n_is_char = 1'b0;
                            n_state   = S_SINGLE;
                        end
                        ACT_CHAR: begin
                            n_byte    = i_byte_value;
                            n_is_char = 1'b1;
                            n_state   = S_SINGLE;
                        end
                        ACT_CURSOR: begin
                            n_byte    = CURSOR_CMD | cursor_addr;
                            n_is_char = 1'b0;
                            n_state   = S_SINGLE;
                        end
                        default: begin
                            n_neg          = i_number[31];
                            bcd_ctrl.start = 1'b1;
                            n_state        = S_CONV;
                        end
                    endcase
                end
            end
            S_SINGLE: begin
                ser_req.push      = 1'b1;
                ser_req.data      = r_byte;
                ser_req.is_char   = r_is_char;
                ser_req.last_byte = 1'b1;
                if (ser_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_CONV: begin
                n_left = LEFT_W'(BCD_DIGITS);
                if (bcd_stat.done) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                // Drop leading zero digits, keep at least one
                if ((bcd_stat.top_digit == 4'd0) && (r_left > LEFT_W'(1))) begin
                    bcd_ctrl.shift = 1'b1;
                    n_left         = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                ser_req.push      = 1'b1;
                ser_req.data      = MINUS_CHAR;
                ser_req.is_char   = 1'b1;
                ser_req.last_byte = 1'b0;
                if (ser_ready) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                ser_req.push      = 1'b1;
                ser_req.data      = {DIGIT_HI, bcd_stat.top_digit};
                ser_req.is_char   = 1'b1;
                ser_req.last_byte = (r_left == LEFT_W'(1));
                if (ser_ready) begin
                    bcd_ctrl.shift = 1'b1;
                    n_left         = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and request registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_byte    <= n_byte;
        r_is_char <= n_is_char;
        r_neg     <= n_neg;
        r_left    <= n_left;
    end

    clbe_bcd_conv u_bcd_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (bcd_ctrl),
        .i_mag   (mag),
        .o_stat  (bcd_stat)
    );

    clbe_byte_ser u_byte_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (ser_req),
        .o_req_ready     (ser_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_expander_byte (o_expander_byte),
        .o_last          (o_last)
    );

    // Checks
    `CLBE_ASSERT_NOW(a_last_enable_low, o_out_valid && o_last, !o_expander_byte[2])
    `CLBE_ASSERT_NOW(a_backlight_on, o_out_valid, o_expander_byte[3] && !o_expander_byte[1])
    `CLBE_ASSERT_NEXT(a_busy_after_accept, in_beat, !o_in_ready)
    `CLBE_ASSERT_NOW(a_done_in_conv, bcd_stat.done, r_state == S_CONV)

endmodule

`default_nettype wire

// ===== src/clbe_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// clbe_bcd_conv
// Binary to BCD converter: one shift-and-add-3 step per cycle, 32 steps.
// After conversion the digit register shifts out one digit per request.
// ----------------------------------------------------------------------------
`default_nettype none

module clbe_bcd_conv (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire clbe_pkg::t_bcd_ctrl i_ctrl,
    input  wire logic [31:0]         i_mag,
    output clbe_pkg::t_bcd_stat      o_stat
);
    import clbe_pkg::*;

    logic [MAG_W-1:0]  r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [ITER_W-1:0] r_iter;
    logic              r_busy;
    logic              r_done;
    logic [BCD_W-1:0]  adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                      : r_bcd[4*d +: 4];
        end
    end

    // Iterate the shared shift unit, then shift digits out on request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == ITER_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload: binary and digit shift registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= {adj[BCD_W-2:0], r_bin[MAG_W-1]};
            r_bin <= {r_bin[MAG_W-2:0], 1'b0};
        end else if (i_ctrl.shift) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'h0};
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ===== src/clbe_byte_ser.sv =====
// ----------------------------------------------------------------------------
// clbe_byte_ser
// Splits one display byte into four expander beats: high nibble with enable
// high and low, then low nibble with enable high and low.
// ----------------------------------------------------------------------------
`default_nettype none

module clbe_byte_ser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire clbe_pkg::t_ser_req i_req,
    output logic                    o_req_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_expander_byte,
    output logic                    o_last
);
    import clbe_pkg::*;

    logic       r_active;
    logic [1:0] r_phase;
    logic [7:0] r_byte;
    logic       r_is_char;
    logic       r_last_byte;
    logic [3:0] nib;
    logic [3:0] ctl;
    logic       beat_done;

    assign beat_done   = r_active && i_out_ready;
    assign o_req_ready = !r_active || (beat_done && (r_phase == 2'd3));

    // Advance the phase per beat, load a new byte after the fourth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= 2'd0;
        end else if (i_req.push && o_req_ready) begin
            r_active <= 1'b1;
            r_phase  <= 2'd0;
        end else if (beat_done) begin
            r_phase <= r_phase + 2'd1;
            if (r_phase == 2'd3) begin
                r_active <= 1'b0;
            end
        end
    end

    // Hold the byte payload
    always_ff @(posedge i_clk) begin
        if (i_req.push && o_req_ready) begin
            r_byte      <= i_req.data;
            r_is_char   <= i_req.is_char;
            r_last_byte <= i_req.last_byte;
        end
    end

    // Build the beat from the held byte and the phase
    always_comb begin
        nib = r_phase[1] ? r_byte[3:0] : r_byte[7:4];
        if (r_is_char) begin
            ctl = r_phase[0] ? CTL_OFF_CHAR : CTL_ON_CHAR;
        end else begin
            ctl = r_phase[0] ? CTL_OFF_CMD : CTL_ON_CMD;
        end
    end

    assign o_out_valid     = r_active;
    assign o_expander_byte = {nib, ctl};
    assign o_last          = r_last_byte && (r_phase == 2'd3);

endmodule

`default_nettype wire

// ===== bench/char_lcd_expander_byte_encoder_top_test.sv =====
// ----------------------------------------------------------------------------
// char_lcd_expander_byte_encoder_top_test
// Self-checking bench for the display request encoder. Requests go in through
// a bursty driver; every expander byte out is compared with a prediction
// built from the request (command, character, cursor and decimal integer).
// ----------------------------------------------------------------------------
module char_lcd_expander_byte_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import clbe_pkg::*;

    localparam int RANDOM_REQUESTS = 176;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 120;

    typedef struct {
        bit [1:0]         action;
        bit [7:0]         byte_value;
        bit [7:0]         column;
        bit [7:0]         row;
        bit signed [31:0] number;
        bit               hold_for_drain;
    } display_request_t;

    typedef struct {
        bit [7:0] expander_byte;
        bit       last;
    } expander_beat_t;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_action        = '0;
    logic [7:0]  i_byte_value    = '0;
    logic [7:0]  i_column        = '0;
    logic [7:0]  i_row           = '0;
    logic signed [31:0] i_number = '0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_expander_byte;
    logic        o_last;

    display_request_t pending_requests[$];
    expander_beat_t   expected_beats[$];

    int failures      = 0;
    int beats_checked = 0;
    int requests_sent = 0;
    int action_count[4];

    char_lcd_expander_byte_encoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_byte_value    (i_byte_value),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_number        (i_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_expander_byte (o_expander_byte),
        .o_last          (o_last)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Split one display byte into its four expander beats
    function automatic void queue_display_byte(input bit [7:0] value, input bit is_char,
                                               input bit is_final);
        bit [3:0] ctl_on;
        bit [3:0] ctl_off;
        expander_beat_t beat;
        ctl_on  = is_char ? CTL_ON_CHAR  : CTL_ON_CMD;
        ctl_off = is_char ? CTL_OFF_CHAR : CTL_OFF_CMD;
        beat.last = 1'b0;
        beat.expander_byte = {value[7:4], ctl_on};
        expected_beats.push_back(beat);
        beat.expander_byte = {value[7:4], ctl_off};
        expected_beats.push_back(beat);
        beat.expander_byte = {value[3:0], ctl_on};
        expected_beats.push_back(beat);
        beat.expander_byte = {value[3:0], ctl_off};
        beat.last = is_final;
        expected_beats.push_back(beat);
    endfunction

    // Work out the expander beats one accepted request must produce
    function automatic void predict_expander_bytes(input display_request_t req);
        bit [7:0]  line_start;
        bit [7:0]  ddram_addr;
        bit [31:0] magnitude;
        bit [3:0]  digit_buf[10];
        int        digit_cnt;
        case (req.action)
            ACT_CMD: queue_display_byte(req.byte_value, 1'b0, 1'b1);
            ACT_CHAR: queue_display_byte(req.byte_value, 1'b1, 1'b1);
            ACT_CURSOR: begin
                // Clamp the row to the last line, then wrap the address to 8 bits
                case (req.row)
                    8'd0:    line_start = 8'h00;
                    8'd1:    line_start = 8'h40;
                    8'd2:    line_start = 8'h14;
                    default: line_start = 8'h54;
                endcase
                ddram_addr = req.column + line_start;
                queue_display_byte(CURSOR_CMD | ddram_addr, 1'b0, 1'b1);
            end
            default: begin
                // Decimal digits, least significant first; zero yields one digit
                magnitude = req.number[31] ? (32'd0 - req.number) : req.number;
                digit_cnt = 0;
                do begin
                    digit_buf[digit_cnt] = 4'(magnitude % 10);
                    magnitude = magnitude / 10;
                    digit_cnt++;
                end while (magnitude != 0);
                if (req.number[31])
                    queue_display_byte(MINUS_CHAR, 1'b1, 1'b0);
                for (int i = digit_cnt - 1; i >= 0; i--)
                    queue_display_byte({DIGIT_HI, digit_buf[i]}, 1'b1, i == 0);
            end
        endcase
    endfunction

    function automatic void add_request(input bit [1:0] action, input bit [7:0] byte_value,
                                        input bit [7:0] column, input bit [7:0] row,
                                        input bit signed [31:0] number,
                                        input bit hold_for_drain);
        display_request_t req;
        req.action         = action;
        req.byte_value     = byte_value;
        req.column         = column;
        req.row            = row;
        req.number         = number;
        req.hold_for_drain = hold_for_drain;
        pending_requests.push_back(req);
    endfunction

    // Integers spread over every digit count, with boundaries and extremes
    function automatic bit signed [31:0] random_number();
        bit [31:0] value;
        int        limit;
        int        digits;
        digits = $urandom_range(1, 9);
        limit  = 1;
        repeat (digits) limit = limit * 10;
        case ($urandom_range(0, 4))
            0: value = $urandom();
            1: value = $urandom_range(0, limit - 1);
            2: value = limit - $urandom_range(0, 1);
            3: value = 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: value = $urandom_range(0, 99);
        endcase
        if ($urandom_range(0, 1) == 1)
            value = 32'd0 - value;
        return value;
    endfunction

    // Fill the request queue, then wait for the run to drain
    initial begin
        bit [1:0] act;
        bit [7:0] row_pick;
        // Commands, including clear, and characters at the byte extremes
        add_request(ACT_CMD,  8'h01, 8'h00, 8'h00, 32'sd0, 1'b0);
        add_request(ACT_CMD,  8'h00, 8'hFF, 8'hFF, -32'sd1, 1'b0);
        add_request(ACT_CMD,  8'hFF, 8'h5A, 8'hA5, 32'sd12345, 1'b0);
        add_request(ACT_CHAR, 8'h00, 8'h00, 8'h00, 32'sd0, 1'b0);
        add_request(ACT_CHAR, 8'hFF, 8'h00, 8'h00, 32'sd0, 1'b0);
        add_request(ACT_CHAR, 8'h41, 8'h00, 8'h00, 32'sd0, 1'b0);
        add_request(ACT_CHAR, 8'hA5, 8'h00, 8'h00, 32'sd0, 1'b0);
        // Cursor on every row, a clamped row and an address that wraps
        add_request(ACT_CURSOR, 8'h00, 8'h00, 8'h00, 32'sd0, 1'b0);
        add_request(ACT_CURSOR, 8'hFF, 8'h05, 8'h01, 32'sd0, 1'b0);
        add_request(ACT_CURSOR, 8'h00, 8'h13, 8'h02, 32'sd0, 1'b0);
        add_request(ACT_CURSOR, 8'h00, 8'hFF, 8'h03, 32'sd0, 1'b1);
        add_request(ACT_CURSOR, 8'h00, 8'h07, 8'h04, 32'sd0, 1'b0);
        add_request(ACT_CURSOR, 8'h00, 8'hAB, 8'hFF, 32'sd0, 1'b0);
        add_request(ACT_CURSOR, 8'h00, 8'h80, 8'h00, 32'sd0, 1'b0);
        // Integers: zero, signs, digit boundaries, both extremes
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, 32'sd0, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, 32'sd1, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, -32'sd1, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, 32'sd9, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, 32'sd10, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, -32'sd10, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, 32'sd2147483647, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, 32'h8000_0000, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, 32'sd1000000000, 1'b0);
        add_request(ACT_NUMBER, 8'h00, 8'h00, 8'h00, -32'sd999999999, 1'b0);

        // Random requests; unused fields carry random bits too
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            act      = 2'($urandom_range(0, 3));
            row_pick = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            add_request(act, 8'($urandom), 8'($urandom), row_pick, random_number(),
                        n == RANDOM_REQUESTS / 2 || n == 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last request to go in and its beats to come out
        while (pending_requests.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (cmd %0d, char %0d, cursor %0d, integer %0d)",
                 requests_sent, action_count[ACT_CMD], action_count[ACT_CHAR],
                 action_count[ACT_CURSOR], action_count[ACT_NUMBER]);
        $display("compared %0d expander bytes, %0d mismatches", beats_checked, failures);
        if (failures == 0) begin
            $display("char_lcd_expander_byte_encoder_top regression: pass");
        end else begin
            $display("char_lcd_expander_byte_encoder_top regression: fail");
        end
        $finish;
    end

    // Request driver: bursts of beats separated by random gaps
    always @(posedge i_clk) begin : drive_requests
        display_request_t held_req;
        display_request_t next_req;
        bit present;
        int burst_left;
        int gap_left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else if (!i_in_valid || o_in_ready) begin
            // Log the accepted beat before picking the next one
            if (i_in_valid) begin
                predict_expander_bytes(held_req);
                requests_sent++;
                action_count[held_req.action]++;
            end
            present = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() != 0 &&
                         (!pending_requests[0].hold_for_drain ||
                          expected_beats.size() == 0)) begin
                next_req = pending_requests.pop_front();
                present  = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            i_in_valid <= present;
            if (present) begin
                held_req = next_req;
                i_action     <= next_req.action;
                i_byte_value <= next_req.byte_value;
                i_column     <= next_req.column;
                i_row        <= next_req.row;
                i_number     <= next_req.number;
            end
        end
    end

    // Result backpressure: pick a new stall style each time the phase counter wraps
    always @(posedge i_clk) begin : stall_results
        int mode;
        int phase_cnt;
        int hold_cnt;
        if (phase_cnt == 0)
            mode = $urandom_range(0, 3);
        phase_cnt = (phase_cnt + 1) % 128;
        case (mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                // Toggle ready, then hold it at that level until the random hold count runs out
                if (hold_cnt == 0) begin
                    i_out_ready <= ~i_out_ready;
                    hold_cnt = $urandom_range(1, 20);
                end else begin
                    hold_cnt--;
                end
            end
        endcase
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : check_beats
        expander_beat_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: expander_byte %h last %b", o_expander_byte, o_last);
                failures++;
            end else begin
                want = expected_beats.pop_front();
                if (o_expander_byte !== want.expander_byte) begin
                    $error("expander_byte: expected %h, got %h",
                           want.expander_byte, o_expander_byte);
                    failures++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    failures++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles, %0d beats outstanding",
                         idle_cycles, expected_beats.size());
                $display("char_lcd_expander_byte_encoder_top regression: fail");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
+incdir+src
src/clbe_pkg.sv
src/clbe_bcd_conv.sv
src/clbe_byte_ser.sv
src/char_lcd_expander_byte_encoder_top.sv
bench/char_lcd_expander_byte_encoder_top_test.sv
